// ----- hw/rtl/array_delete_first_match_unit_assert.svh -----
// Assertion macros shared by the array delete unit RTL.
// Uses the clock and reset names of the including module; no other dependencies.
`ifndef ARRAY_DELETE_FIRST_MATCH_UNIT_ASSERT_SVH
`define ARRAY_DELETE_FIRST_MATCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ADU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ADU_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define ADU_ASSERT(lbl, prop, msg)
`define ADU_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hw/rtl/adu_pkg.sv -----
// Shared constants and types for the array delete unit.
// No dependencies; used by adu_ctrl and the top level.
package adu_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 6;
   localparam int ACTION_W   = 2;
   localparam int POS_W      = 7;
   localparam int FILL_W     = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [POS_W-1:0] NO_POSITION = 7'h7F;

   typedef struct packed {
      logic [VALUE_W-1:0] read_data;
      logic [FILL_W-1:0]  fill_count;
      logic [POS_W-1:0]   position;
      logic               found;
   } res_type;

endpackage

// ----- hw/rtl/adu_mem.sv -----
// Entry store of the array delete unit: one write port, one read port,
// registered read data. Depends on nothing.
module adu_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/adu_ctrl.sv -----
// Sequencer of the array delete unit: fill count, search and shift walks,
// one shared equality compare. Depends on adu_pkg and the assertion header.
`include "array_delete_first_match_unit_assert.svh"

module adu_ctrl #(
   parameter int DEPTH = adu_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [adu_pkg::ACTION_W-1:0]    req_action,
   input  logic [adu_pkg::VALUE_W-1:0]     req_value,
   input  logic [adu_pkg::INDEX_W-1:0]     req_index,
   output logic                            res_valid,
   input  logic                            res_ready,
   output adu_pkg::res_type                res,
   output logic                            mem_we,
   output logic [AW-1:0]                   mem_waddr,
   output logic [adu_pkg::VALUE_W-1:0]     mem_wdata,
   output logic                            mem_re,
   output logic [AW-1:0]                   mem_raddr,
   input  logic [adu_pkg::VALUE_W-1:0]     mem_rdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_READ,
      ST_DONE
   } state_type;

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   ptr_ff, ptr_in;
   logic                            pend_vld_ff, pend_vld_in;
   logic [CW-1:0]                   pend_idx_ff, pend_idx_in;
   logic [adu_pkg::VALUE_W-1:0]     value_ff, value_in;
   logic                            found_ff, found_in;
   logic [adu_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [adu_pkg::VALUE_W-1:0]     data_ff, data_in;

   logic                            accept;
   logic                            match;
   logic [CW+adu_pkg::INDEX_W-1:0]  idx_ext;
   logic [CW+adu_pkg::INDEX_W-1:0]  cnt_ext;
   logic [CW+adu_pkg::POS_W-1:0]    pend_ext;
   logic [CW+adu_pkg::FILL_W-1:0]   fill_ext;
   logic [CW-1:0]                   wr_idx;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == ST_DONE);

   // shared compare: fetched entry against the search value
   assign match = pend_vld_ff && (mem_rdata == value_ff);

   assign idx_ext  = {{CW{1'b0}}, req_index};
   assign cnt_ext  = {{adu_pkg::INDEX_W{1'b0}}, count_ff};
   assign pend_ext = {{adu_pkg::POS_W{1'b0}}, pend_idx_ff};
   assign fill_ext = {{adu_pkg::FILL_W{1'b0}}, count_ff};
   assign wr_idx   = pend_idx_ff - ONE_C;

   assign res.found      = found_ff;
   assign res.position   = pos_ff;
   assign res.fill_count = fill_ext[adu_pkg::FILL_W-1:0];
   assign res.read_data  = data_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      value_in    = value_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      data_in     = data_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = mem_rdata;
      mem_re      = 1'b0;
      mem_raddr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in    = req_value;
               ptr_in      = '0;
               pend_vld_in = 1'b0;
               found_in    = 1'b0;
               pos_in      = adu_pkg::NO_POSITION;
               data_in     = '0;
               state_in    = ST_DONE;
               case (req_action)
                  adu_pkg::ACT_APPEND: begin
                     if (count_ff < DEPTH_C) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_value;
                        count_in  = count_ff + ONE_C;
                        found_in  = 1'b1;
                     end
                  end
                  adu_pkg::ACT_DELETE: begin
                     state_in = ST_SEARCH;
                  end
                  adu_pkg::ACT_READ: begin
                     if (idx_ext < cnt_ext) begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_ext[AW-1:0];
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (match) begin
               // remove this entry, then pull the tail down from the next one
               found_in    = 1'b1;
               pos_in      = pend_ext[adu_pkg::POS_W-1:0];
               count_in    = count_ff - ONE_C;
               ptr_in      = pend_idx_ff + ONE_C;
               pend_vld_in = 1'b0;
               state_in    = ST_SHIFT;
            end else if (ptr_ff < count_ff) begin
               mem_re      = 1'b1;
               mem_raddr   = ptr_ff[AW-1:0];
               pend_idx_in = ptr_ff;
               pend_vld_in = 1'b1;
               ptr_in      = ptr_ff + ONE_C;
            end else begin
               pend_vld_in = 1'b0;
               if (!pend_vld_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT: begin
            if (pend_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_idx[AW-1:0];
               mem_wdata = mem_rdata;
            end
            if (ptr_ff <= count_ff) begin
               mem_re      = 1'b1;
               mem_raddr   = ptr_ff[AW-1:0];
               pend_idx_in = ptr_ff;
               pend_vld_in = 1'b1;
               ptr_in      = ptr_ff + ONE_C;
            end else begin
               pend_vld_in = 1'b0;
               if (!pend_vld_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            data_in  = mem_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
      end
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      value_ff    <= value_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      data_ff     <= data_in;
   end

   `ADU_NEVER(a_count_bound, count_ff > DEPTH_C, "fill count above depth")
   `ADU_ASSERT(a_busy_after_accept, accept |=> !req_ready, "ready right after accept")
   `ADU_ASSERT(a_shift_in_range, (state_ff == ST_SHIFT && mem_we) |-> (wr_idx < count_ff), "shift write beyond fill")
   `ADU_ASSERT(a_pos_means_found, (res_valid && res.position != adu_pkg::NO_POSITION) |-> res.found, "position without found")

endmodule

// ----- hw/rtl/array_delete_first_match_unit.sv -----
// Top level of the array delete unit: stream ports, output register,
// sequencer and entry store. Depends on adu_pkg, adu_ctrl and adu_mem.
//
//  channel   dir  handshake            payload
//  req_      in   req_tvalid/tready    tuser: action; tdata: value, index
//  rsp_      out  rsp_tvalid/tready    tdata: found, position, fill_count, read_data
//
// Append, the unused action and a read past the fill count finish straight from idle;
// a read in range fetches its entry first. Delete walks the store with a search pass
// and, on a hit, a shift pass, through the single read and single write port of the store.
// Synchronous active-high reset empties the array at once (fill count to 0).
// One word is in the sequencer at a time; the output register lets it take
// the next word while the previous result waits on rsp_tready.
module array_delete_first_match_unit #(
   parameter int DEPTH = adu_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [adu_pkg::REQ_DATA_W-1:0]     req_tdata,  // value[31:0], index[37:32], zero
   input  logic [adu_pkg::ACTION_W-1:0]       req_tuser,  // action[1:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [adu_pkg::RSP_DATA_W-1:0]     rsp_tdata   // found[0], position[7:1],
                                                          // fill_count[14:8],
                                                          // read_data[46:15], zero
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   adu_pkg::res_type             res;
   logic                         res_valid;
   logic                         res_ready;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [adu_pkg::VALUE_W-1:0]  mem_wdata;
   logic                         mem_re;
   logic [AW-1:0]                mem_raddr;
   logic [adu_pkg::VALUE_W-1:0]  mem_rdata;

   logic                         out_vld_ff, out_vld_in;
   adu_pkg::res_type             out_ff, out_in;

   adu_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_value  (req_tdata[31:0]),
      .req_index  (req_tdata[37:32]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   adu_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (adu_pkg::VALUE_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // take a new result when the output word is empty or leaving
   assign res_ready = !out_vld_ff || rsp_tready;

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (res_ready) begin
         out_vld_in = res_valid;
         if (res_valid) begin
            out_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff.read_data, out_ff.fill_count,
                        out_ff.position, out_ff.found};

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for array_delete_first_match_unit: append, delete and read words
// go in on the req_ stream and are checked on the rsp_ stream against an in-bench store.
// Depends on adu_pkg and the RTL top level only.
module tb_top;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int STORE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT = 300;
   localparam int RANDOM_ITEMS = 1400;

   typedef struct {
      logic [adu_pkg::ACTION_W-1:0] action;
      logic [adu_pkg::VALUE_W-1:0]  value;
      logic [adu_pkg::INDEX_W-1:0]  index;
      int                           gap;
      bit                           drain;
   } req_item_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [adu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [adu_pkg::ACTION_W-1:0]   req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [adu_pkg::RSP_DATA_W-1:0] rsp_tdata;

   req_item_type       req_backlog[$];
   adu_pkg::res_type   expected_results[$];
   req_item_type       cur_item;
   int           gap_left = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;
   int           results_seen = 0;
   int           errors = 0;
   int           cycles = 0;

   // in-bench copy of the entry store
   logic [adu_pkg::VALUE_W-1:0] store_words[STORE_DEPTH];
   int unsigned                 store_fill = 0;

   logic [adu_pkg::VALUE_W-1:0] value_pool[8] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                                  32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h0000_0007, 32'h1234_5678,
                                                  32'hA5A5_5A5A, 32'h0000_0001};

   array_delete_first_match_unit #(.DEPTH(STORE_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one word to the store copy and return the result it should produce.
   function automatic adu_pkg::res_type apply_to_store(
         logic [adu_pkg::ACTION_W-1:0] action,
         logic [adu_pkg::VALUE_W-1:0]  value,
         logic [adu_pkg::INDEX_W-1:0]  index);
      adu_pkg::res_type res;
      int unsigned      i;
      int               hit;
      res.found      = 1'b0;
      res.position   = adu_pkg::NO_POSITION;
      res.read_data  = '0;
      hit = -1;
      case (action)
         adu_pkg::ACT_APPEND: begin
            if (store_fill < STORE_DEPTH) begin
               store_words[store_fill] = value;
               store_fill++;
               res.found = 1'b1;
            end
         end
         adu_pkg::ACT_DELETE: begin
            for (i = 0; i < store_fill; i++)
               if (hit < 0 && store_words[i] == value) hit = i;
            if (hit >= 0) begin
               res.found    = 1'b1;
               res.position = adu_pkg::POS_W'(hit);
               store_fill--;
               for (i = hit; i < store_fill; i++) store_words[i] = store_words[i + 1];
            end
         end
         adu_pkg::ACT_READ: begin
            if (index < store_fill) res.read_data = store_words[index];
         end
         default: ;
      endcase
      res.fill_count = adu_pkg::FILL_W'(store_fill);
      return res;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   function automatic req_item_type make_item(logic [adu_pkg::ACTION_W-1:0] action,
                                              logic [adu_pkg::VALUE_W-1:0] value,
                                              logic [adu_pkg::INDEX_W-1:0] index,
                                              int gap);
      req_item_type it;
      it.action = action;
      it.value  = value;
      it.index  = index;
      it.gap    = gap;
      it.drain  = 1'b0;
      return it;
   endfunction

   function automatic logic [adu_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return value_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [adu_pkg::INDEX_W-1:0] pick_index();
      return adu_pkg::INDEX_W'($urandom_range(0, 63));
   endfunction

   // Driver: hold the word until accepted, predict on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_to_store(cur_item.action, cur_item.value,
                                                      cur_item.index));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain && expected_results.size() != 0)) begin
               cur_item = req_backlog.pop_front();
               req_tdata  <= {2'b00, cur_item.index, cur_item.value};
               req_tuser  <= cur_item.action;
               req_tvalid <= 1'b1;
               gap_left   <= cur_item.gap;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, one long hold-off, and a quiet window.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            stall_left <= pick_gap(results_seen >= 900 && results_seen < 1050);
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      adu_pkg::res_type got;
      adu_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = adu_pkg::res_type'(rsp_tdata[$bits(adu_pkg::res_type)-1:0]);
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.found !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
               errors++;
            end
            if (got.position !== want.position) begin
               $display("%0t: position expected %0d actual %0d", $time,
                        $signed(want.position), $signed(got.position));
               errors++;
            end
            if (got.fill_count !== want.fill_count) begin
               $display("%0t: fill_count expected %0d actual %0d", $time,
                        want.fill_count, got.fill_count);
               errors++;
            end
            if (got.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h", $time,
                        want.read_data, got.read_data);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int          made;
      int          phase_len;
      int          kind;
      int          r;
      bit          quiet;
      bit          drain_set;
      logic [adu_pkg::ACTION_W-1:0] act;

      // directed: empty store, extremes, duplicates, out-of-range reads, unused action
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_DELETE, 32'h5, 6'd0, 1));
      req_backlog.push_back(make_item(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_APPEND, 32'h8000_0000, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_APPEND, 32'h7FFF_FFFF, 6'd63, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_APPEND, 32'h0000_0000, 6'd0, 2));
      req_backlog.push_back(make_item(adu_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_APPEND, 32'h0000_0007, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_APPEND, 32'h0000_0007, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'hFFFF_FFFF, 6'd3, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd6, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd63, 3));
      req_backlog.push_back(make_item(adu_pkg::ACT_DELETE, 32'h0000_0007, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd4, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_DELETE, 32'h0000_0007, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_DELETE, 32'h0000_0007, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_DELETE, 32'h8000_0000, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_DELETE, 32'hFFFF_FFFF, 6'd0, 0));
      req_backlog.push_back(make_item(ACT_UNUSED, 32'h1234_5678, 6'd21, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd0, 0));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd1, 0));

      // fill to the top, then push appends into a full store
      for (made = 0; made < STORE_DEPTH + 6; made++)
         req_backlog.push_back(make_item(adu_pkg::ACT_APPEND, pick_value(), pick_index(),
                                         pick_gap(1'b0)));
      req_backlog.push_back(make_item(adu_pkg::ACT_READ, 32'h0, 6'd63, 0));

      drain_set = 1'b0;
      while (made < RANDOM_ITEMS) begin
         phase_len = $urandom_range(40, 120);
         kind      = $urandom_range(0, 2);
         quiet     = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            r = $urandom_range(0, 99);
            case (kind)
               0: act = (r < 80) ? adu_pkg::ACT_APPEND : (r < 90) ? adu_pkg::ACT_READ :
                        (r < 98) ? adu_pkg::ACT_DELETE : ACT_UNUSED;
               1: act = (r < 70) ? adu_pkg::ACT_DELETE : (r < 85) ? adu_pkg::ACT_READ :
                        (r < 97) ? adu_pkg::ACT_APPEND : ACT_UNUSED;
               default: act = (r < 35) ? adu_pkg::ACT_APPEND :
                              (r < 65) ? adu_pkg::ACT_DELETE :
                              (r < 95) ? adu_pkg::ACT_READ : ACT_UNUSED;
            endcase
            req_backlog.push_back(make_item(act, pick_value(), pick_index(),
                                            pick_gap(quiet)));
            made++;
            // pause the sender once until the block has drained
            if (!drain_set && made >= 700) begin
               req_backlog[$].drain = 1'b1;
               drain_set = 1'b1;
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
